// ===== design/c8ic_pkg.sv =====
// Package for the CHIP-8 instruction core: item kinds, opcode groups and sequencer types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package c8ic_pkg;
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_EXEC = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [3:0] GRP_SYS   = 4'h0;
	localparam logic [3:0] GRP_JP    = 4'h1;
	localparam logic [3:0] GRP_CALL  = 4'h2;
	localparam logic [3:0] GRP_SEQK  = 4'h3;
	localparam logic [3:0] GRP_SNEK  = 4'h4;
	localparam logic [3:0] GRP_SEQV  = 4'h5;
	localparam logic [3:0] GRP_LDK   = 4'h6;
	localparam logic [3:0] GRP_ADDK  = 4'h7;
	localparam logic [3:0] GRP_ALU   = 4'h8;
	localparam logic [3:0] GRP_SNEV  = 4'h9;
	localparam logic [3:0] GRP_LDI   = 4'hA;
	localparam logic [3:0] GRP_JPV0  = 4'hB;
	localparam logic [3:0] GRP_DRW   = 4'hD;

	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_SBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	// Result flags passed from the sequencer to the output stage.
	typedef struct packed {
		logic drawn;
		logic unsup;
		logic fault;
	} c8ic_flags_t;

	// Shared 8-bit ALU result.
	typedef struct packed {
		logic [7:0] res;
		logic       flag;
	} c8ic_alu_t;

	function automatic c8ic_alu_t c8ic_alu(input logic [3:0] fn, input logic [7:0] a,
			input logic [7:0] b);
		c8ic_alu_t r;
		logic [8:0] s;
		s = 9'd0;
		r.res = b;
		r.flag = 1'b0;
		case (fn)
			ALU_MOV: r.res = b;
			ALU_OR:  r.res = a | b;
			ALU_AND: r.res = a & b;
			ALU_XOR: r.res = a ^ b;
			ALU_ADD: begin
				s = {1'b0, a} + {1'b0, b};
				r.res = s[7:0];
				r.flag = s[8];
			end
			ALU_SUB: begin
				r.res = a - b;
				r.flag = (a >= b);
			end
			ALU_SHR: begin
				r.res = {1'b0, a[7:1]};
				r.flag = a[0];
			end
			ALU_SBN: begin
				r.res = b - a;
				r.flag = (b >= a);
			end
			ALU_SHL: begin
				r.res = {a[6:0], 1'b0};
				r.flag = a[7];
			end
			default: r.res = b;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== design/c8ic_frame.sv =====
// Frame store of the CHIP-8 core: 32 rows of 64 pixels, one row read and one row written per cycle.
// Depends on c8ic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module c8ic_frame
	import c8ic_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        clr,
	input  wire logic        we,
	input  wire logic [4:0]  waddr,
	input  wire logic [63:0] wdata,
	input  wire logic [4:0]  raddr,
	output logic      [63:0] rdata
);
	logic [63:0] row_q [32];
	logic [31:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			row_q[waddr] <= wdata;
		end
	end

	// Rows never written since the last clear read as blank.
	always_ff @(posedge clk) begin
		rdata <= (valid_q[raddr] && !(we && waddr == raddr)) ? row_q[raddr] :
			((we && waddr == raddr) ? wdata : 64'd0);
	end
endmodule
`default_nettype wire

// ===== design/chip8_instruction_core_top.sv =====
// Top level of the CHIP-8 instruction core: stream ports, memory, registers and sequencer.
// Depends on c8ic_pkg and c8ic_frame.
`timescale 1ns / 1ps
`default_nettype none
// One request is taken at a time and the core is not ready until its result is out.
// A load or display read passes through the row read and output states, and a simple
// instruction through two byte fetches from the single memory read port, register
// read, execute, row read and output. A return adds a state that loads the program
// counter from the stack, and a clear needs no extra state since the frame store drops
// its row valid bits at once. A draw of n rows (at most 15) steps through a memory byte
// fetch, a frame row read and a frame row write for each sprite row. A result still
// waiting at the output holds the core in its output state until it is taken.
// No clearing pass is needed.
module chip8_instruction_core_top
	import c8ic_pkg::*;
#(
	parameter int PROGRAM_BASE = 512,
	parameter int STACK_LEVELS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// low to high: load_offset[11:0], load_byte[19:12], row_select[24:20], zero fill
	input  wire logic [31:0]  s_tdata,
	// kind[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// low to high: pc_now[11:0], index_now[23:12], flag_byte[31:24],
	// display_row[95:32], draw_flag[96], unsupported[97], stack_fault[98], zero fill
	output logic      [103:0] m_tdata
);
	localparam int SW = $clog2(STACK_LEVELS + 1);
	localparam logic [11:0] BASE = 12'(PROGRAM_BASE);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_F0    = 4'd1;
	localparam logic [3:0] ST_F1    = 4'd2;
	localparam logic [3:0] ST_DEC   = 4'd3;
	localparam logic [3:0] ST_EXE   = 4'd4;
	localparam logic [3:0] ST_DRM   = 4'd5;
	localparam logic [3:0] ST_DRF   = 4'd6;
	localparam logic [3:0] ST_DRW   = 4'd7;
	localparam logic [3:0] ST_RD    = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;
	localparam logic [3:0] ST_RET   = 4'd10;

	logic [3:0]  state_q;
	logic [7:0]  mem [4096];
	logic [7:0]  mem_rd_q;
	logic [11:0] mem_ra;
	logic [11:0] stack_q [16];
	logic [SW-1:0] sp_q;
	logic [7:0]  v_q [16];
	logic [11:0] pc_q, idx_q;
	logic [15:0] op_q;
	logic [4:0]  row_sel_q;
	logic [1:0]  kind_q;
	logic [7:0]  vx_q, vy_q;
	logic [3:0]  k_q;
	logic [5:0]  col_q;
	logic [4:0]  yrow_q;
	logic        hit_q;
	logic [7:0]  spr_q;
	c8ic_flags_t fl_q;
	logic [11:0] ret_q;

	logic        f_clr, f_we;
	logic [4:0]  f_waddr, f_raddr;
	logic [63:0] f_wdata, f_rdata, mask;
	logic [63:0] wide;
	c8ic_alu_t   alu;
	logic [3:0]  opx, opn;

	assign opx = op_q[11:8];
	assign opn = op_q[3:0];
	assign s_tready = (state_q == ST_IDLE);
	assign alu = c8ic_alu(opn, vx_q, vy_q);

	c8ic_frame u_frame (
		.clk(clk), .arst_n(arst_n), .clr(f_clr), .we(f_we), .waddr(f_waddr),
		.wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
	);

	always_comb begin
		wide = {spr_q, 56'd0};
		mask = (wide >> col_q) | ((col_q == 6'd0) ? 64'd0 : (wide << (7'd64 - {1'b0, col_q})));
		f_clr = (state_q == ST_EXE) && (op_q == OP_CLS);
		f_we = (state_q == ST_DRW);
		f_waddr = yrow_q + 5'(k_q);
		f_wdata = f_rdata ^ mask;
		f_raddr = (state_q == ST_DRM || state_q == ST_DRF || state_q == ST_DRW) ?
			f_waddr : row_sel_q;
	end

	always_comb begin
		case (state_q)
			ST_F0:   mem_ra = pc_q;
			ST_F1:   mem_ra = pc_q + 12'd1;
			default: mem_ra = idx_q + 12'(k_q);
		endcase
	end

	always_ff @(posedge clk) begin
		mem_rd_q <= mem[mem_ra];
		if (s_tvalid && s_tready && s_tuser == KIND_LOAD) begin
			mem[BASE + s_tdata[11:0]] <= s_tdata[19:12];
		end
		ret_q <= stack_q[4'(sp_q - SW'(1))];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXE && op_q[15:12] == GRP_CALL && sp_q < SW'(STACK_LEVELS)) begin
			stack_q[4'(sp_q)] <= pc_q + 12'd2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid <= 1'b0;
			pc_q <= BASE;
			idx_q <= '0;
			sp_q <= '0;
			for (int i = 0; i < 16; i++) v_q[i] <= '0;
			fl_q <= '0;
			k_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_OUT) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						kind_q <= s_tuser;
						row_sel_q <= s_tdata[24:20];
						fl_q <= '0;
						state_q <= (s_tuser == KIND_EXEC) ? ST_F0 : ST_RD;
					end
				end
				ST_F0: state_q <= ST_F1;
				ST_F1: begin
					op_q[15:8] <= mem_rd_q;
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					op_q[7:0] <= mem_rd_q;
					vx_q <= v_q[op_q[11:8]];
					vy_q <= v_q[mem_rd_q[7:4]];
					state_q <= ST_EXE;
				end
				ST_EXE: begin
					state_q <= ST_RD;
					pc_q <= pc_q + 12'd2;
					case (op_q[15:12])
						GRP_SYS: begin
							if (op_q == OP_CLS) fl_q.drawn <= 1'b1;
							else if (op_q == OP_RET) begin
								if (sp_q == '0) fl_q.fault <= 1'b1;
								else state_q <= ST_RET;
							end else fl_q.unsup <= 1'b1;
						end
						GRP_JP: pc_q <= op_q[11:0];
						GRP_CALL: begin
							if (sp_q >= SW'(STACK_LEVELS)) fl_q.fault <= 1'b1;
							else begin
								sp_q <= sp_q + SW'(1);
								pc_q <= op_q[11:0];
							end
						end
						GRP_SEQK: if (vx_q == op_q[7:0]) pc_q <= pc_q + 12'd4;
						GRP_SNEK: if (vx_q != op_q[7:0]) pc_q <= pc_q + 12'd4;
						GRP_SEQV: if (vx_q == vy_q) pc_q <= pc_q + 12'd4;
						GRP_SNEV: if (vx_q != vy_q) pc_q <= pc_q + 12'd4;
						GRP_LDK: v_q[opx] <= op_q[7:0];
						GRP_ADDK: v_q[opx] <= vx_q + op_q[7:0];
						GRP_ALU: begin
							case (opn)
								ALU_MOV, ALU_OR, ALU_AND, ALU_XOR: v_q[opx] <= alu.res;
								ALU_ADD, ALU_SUB, ALU_SHR, ALU_SBN, ALU_SHL: begin
									v_q[opx] <= alu.res;
									v_q[15] <= {7'd0, alu.flag};
								end
								default: fl_q.unsup <= 1'b1;
							endcase
						end
						GRP_LDI: idx_q <= op_q[11:0];
						GRP_JPV0: pc_q <= op_q[11:0] + {4'd0, v_q[0]};
						GRP_DRW: begin
							fl_q.drawn <= 1'b1;
							col_q <= vx_q[5:0];
							yrow_q <= vy_q[4:0];
							k_q <= '0;
							hit_q <= 1'b0;
							if (opn == 4'd0) v_q[15] <= '0;
							else state_q <= ST_DRM;
						end
						default: fl_q.unsup <= 1'b1;
					endcase
				end
				ST_RET: begin
					sp_q <= sp_q - SW'(1);
					pc_q <= ret_q;
					state_q <= ST_RD;
				end
				ST_DRM: state_q <= ST_DRF;
				ST_DRF: begin
					spr_q <= mem_rd_q;
					state_q <= ST_DRW;
				end
				ST_DRW: begin
					if ((f_rdata & mask) != 64'd0) hit_q <= 1'b1;
					if (k_q == opn - 4'd1) begin
						v_q[15] <= {7'd0, hit_q || ((f_rdata & mask) != 64'd0)};
						state_q <= ST_RD;
					end else begin
						k_q <= k_q + 4'd1;
						state_q <= ST_DRM;
					end
				end
				ST_RD: state_q <= ST_OUT;
				ST_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!m_tvalid || m_tready)) begin
			m_tdata <= {5'd0, fl_q.fault, fl_q.unsup, fl_q.drawn, f_rdata, v_q[15], idx_q, pc_q};
		end
	end

	a_stack_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SW'(STACK_LEVELS)) else $error("stack depth beyond limit");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready) else $error("ready while busy");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && kind_q != KIND_EXEC) |-> (fl_q == '0))
		else $error("flags on non-execute request");
endmodule
`default_nettype wire

// ===== tb/chip8_instruction_core_checker.sv =====
// Checker for the CHIP-8 instruction core: watches both stream channels, keeps its own
// copy of the core state, predicts every result and compares it field by field.
// Depends on c8ic_pkg.
`timescale 1ns / 1ps
module chip8_instruction_core_checker
	import c8ic_pkg::*;
#(
	parameter int PROGRAM_BASE = 512,
	parameter int STACK_LEVELS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	// low to high: load_offset[11:0], load_byte[19:12], row_select[24:20], zero fill
	input  wire logic [31:0]  s_tdata,
	// kind[1:0]
	input  wire logic [1:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	// low to high: pc_now, index_now, flag_byte, display_row, draw_flag, unsupported,
	// stack_fault, zero fill
	input  wire logic [103:0] m_tdata,
	output int                fail_count,
	output int                pending
);
	typedef struct packed {
		logic [11:0] pc;
		logic [11:0] idx;
		logic [7:0]  vf;
		logic [63:0] row;
		logic        drawn;
		logic        unsup;
		logic        fault;
	} core_result_t;

	logic [7:0]  mem [4096];
	logic [7:0]  vreg [16];
	logic [11:0] pc;
	logic [11:0] index_reg;
	logic [11:0] ret_stack [16];
	int          depth;
	logic [63:0] frame [32];
	core_result_t expected_q [$];

	initial begin
		fail_count = 0;
		for (int i = 0; i < 4096; i++) mem[i] = 8'd0;
		for (int i = 0; i < 16; i++) begin
			vreg[i] = 8'd0;
			ret_stack[i] = 12'd0;
		end
		for (int i = 0; i < 32; i++) frame[i] = 64'd0;
		pc = PROGRAM_BASE;
		index_reg = 12'd0;
		depth = 0;
	end

	assign pending = expected_q.size();

	// Applies one request to the shadow state and returns the result it should give.
	function automatic core_result_t apply_request(input logic [1:0] kind,
			input logic [11:0] off, input logic [7:0] data, input logic [4:0] row_sel);
		core_result_t r;
		logic [15:0] op;
		logic [11:0] nxt, nnn;
		logic [3:0] x, y, n;
		logic [7:0] kk, vx, vy, bits;
		logic [8:0] sum;
		logic [63:0] m;
		int col, row0;
		logic hit;
		r = '0;
		if (kind == KIND_LOAD) begin
			mem[12'(PROGRAM_BASE + off)] = data;
		end else if (kind == KIND_EXEC) begin
			op = {mem[pc], mem[12'(pc + 1)]};
			nnn = op[11:0];
			x = op[11:8];
			y = op[7:4];
			n = op[3:0];
			kk = op[7:0];
			vx = vreg[x];
			vy = vreg[y];
			nxt = pc + 12'd2;
			case (op[15:12])
				GRP_SYS: begin
					if (op == OP_CLS) begin
						for (int i = 0; i < 32; i++) frame[i] = 64'd0;
						r.drawn = 1'b1;
					end else if (op == OP_RET) begin
						if (depth == 0) r.fault = 1'b1;
						else begin
							depth--;
							nxt = ret_stack[depth];
						end
					end else r.unsup = 1'b1;
				end
				GRP_JP: nxt = nnn;
				GRP_CALL: begin
					if (depth >= STACK_LEVELS) r.fault = 1'b1;
					else begin
						ret_stack[depth] = nxt;
						depth++;
						nxt = nnn;
					end
				end
				GRP_SEQK: if (vx == kk) nxt = pc + 12'd4;
				GRP_SNEK: if (vx != kk) nxt = pc + 12'd4;
				GRP_SEQV: if (vx == vy) nxt = pc + 12'd4;
				GRP_SNEV: if (vx != vy) nxt = pc + 12'd4;
				GRP_LDK:  vreg[x] = kk;
				GRP_ADDK: vreg[x] = vx + kk;
				GRP_ALU: begin
					case (n)
						ALU_MOV: vreg[x] = vy;
						ALU_OR:  vreg[x] = vx | vy;
						ALU_AND: vreg[x] = vx & vy;
						ALU_XOR: vreg[x] = vx ^ vy;
						ALU_ADD: begin
							sum = {1'b0, vx} + {1'b0, vy};
							vreg[x] = sum[7:0];
							vreg[15] = {7'd0, sum[8]};
						end
						ALU_SUB: begin
							vreg[x] = vx - vy;
							vreg[15] = {7'd0, vx >= vy};
						end
						ALU_SHR: begin
							vreg[x] = vx >> 1;
							vreg[15] = {7'd0, vx[0]};
						end
						ALU_SBN: begin
							vreg[x] = vy - vx;
							vreg[15] = {7'd0, vy >= vx};
						end
						ALU_SHL: begin
							vreg[x] = vx << 1;
							vreg[15] = {7'd0, vx[7]};
						end
						default: r.unsup = 1'b1;
					endcase
				end
				GRP_LDI:  index_reg = nnn;
				GRP_JPV0: nxt = nnn + {4'd0, vreg[0]};
				GRP_DRW: begin
					col = vx % 64;
					row0 = vy % 32;
					hit = 1'b0;
					for (int k = 0; k < n; k++) begin
						bits = mem[12'(index_reg + k)];
						m = {bits, 56'd0};
						if (col != 0) m = (m >> col) | (m << (64 - col));
						if ((frame[(row0 + k) % 32] & m) != 64'd0) hit = 1'b1;
						frame[(row0 + k) % 32] ^= m;
					end
					vreg[15] = {7'd0, hit};
					r.drawn = 1'b1;
				end
				default: r.unsup = 1'b1;
			endcase
			pc = nxt;
		end
		r.pc = pc;
		r.idx = index_reg;
		r.vf = vreg[15];
		r.row = frame[row_sel];
		return r;
	endfunction

	always @(posedge clk) begin
		core_result_t e;
		core_result_t a;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_q.push_back(apply_request(s_tuser, s_tdata[11:0], s_tdata[19:12],
					s_tdata[24:20]));
			if (m_tvalid && m_tready) begin
				a = {m_tdata[11:0], m_tdata[23:12], m_tdata[31:24], m_tdata[95:32],
					m_tdata[96], m_tdata[97], m_tdata[98]};
				if (expected_q.size() == 0) begin
					$error("result with no request outstanding: %h", m_tdata);
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					if (e.pc != a.pc) begin
						$error("pc_now expected %h actual %h", e.pc, a.pc);
						fail_count++;
					end
					if (e.idx != a.idx) begin
						$error("index_now expected %h actual %h", e.idx, a.idx);
						fail_count++;
					end
					if (e.vf != a.vf) begin
						$error("flag_byte expected %h actual %h", e.vf, a.vf);
						fail_count++;
					end
					if (e.row != a.row) begin
						$error("display_row expected %h actual %h", e.row, a.row);
						fail_count++;
					end
					if (e.drawn != a.drawn) begin
						$error("draw_flag expected %b actual %b", e.drawn, a.drawn);
						fail_count++;
					end
					if (e.unsup != a.unsup) begin
						$error("unsupported expected %b actual %b", e.unsup, a.unsup);
						fail_count++;
					end
					if (e.fault != a.fault) begin
						$error("stack_fault expected %b actual %b", e.fault, a.fault);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

// ===== tb/chip8_instruction_core_top_tb.sv =====
// Testbench top for the CHIP-8 instruction core: builds programs on the fly, steering
// fetches and sprite reads to written memory, and gives the verdict.
// Depends on c8ic_pkg, chip8_instruction_core_top and chip8_instruction_core_checker.
`timescale 1ns / 1ps
module chip8_instruction_core_top_tb;
	import c8ic_pkg::*;

	localparam logic [3:0] GRP_RND  = 4'hC;
	localparam logic [3:0] GRP_KEY  = 4'hE;
	localparam logic [3:0] GRP_MISC = 4'hF;
	localparam int ITEM_TARGET = 1550;
	localparam int CYCLE_LIMIT = 1000000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [31:0]  s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	int           fail_count;
	int           pending;

	int          send_gap_pct = 0;
	int          recv_stall_pct = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          cycles = 0;
	logic [11:0] cur_pc = 12'd512;
	logic [11:0] cur_idx = 12'd0;
	bit          written [4096];

	chip8_instruction_core_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	chip8_instruction_core_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
		if (m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			cur_pc <= m_tdata[11:0];
			cur_idx <= m_tdata[23:12];
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** chip8_instruction_core_top: FAILED **");
			$finish;
		end
	end

	// One request at a time: the next one is built only after the result of this one,
	// since the program counter and index steer what is safe to run next.
	task automatic send_item(input logic [1:0] kind, input logic [11:0] off,
			input logic [7:0] data, input logic [4:0] row_sel);
		int seen;
		while ($urandom_range(99) < send_gap_pct) @(posedge clk);
		seen = results_seen;
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, row_sel, data, off};
		s_tuser <= kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		s_tvalid <= 1'b0;
		while (results_seen == seen) @(posedge clk);
		items_sent++;
	endtask

	task automatic load_byte(input logic [11:0] addr, input logic [7:0] data);
		send_item(KIND_LOAD, addr - 12'd512, data, 5'($urandom));
		written[addr] = 1'b1;
	endtask

	task automatic run_op(input logic [15:0] op);
		logic [11:0] a;
		if (op[15:12] == GRP_DRW)
			for (int k = 0; k < op[3:0]; k++) begin
				a = cur_idx + 12'(k);
				if (!written[a]) load_byte(a, 8'($urandom));
			end
		a = cur_pc;
		load_byte(a, op[15:8]);
		load_byte(a + 12'd1, op[7:0]);
		send_item(KIND_EXEC, 12'($urandom_range(0, 3583)), 8'($urandom), 5'($urandom));
	endtask

	// Program counter stays within 512..4095 and fetches never wrap into low memory.
	function automatic logic [15:0] pick_op(input logic [11:0] pc, input logic [11:0] idx);
		logic [3:0] fn;
		logic [15:0] op;
		logic [11:0] tgt;
		tgt = 12'($urandom_range(512, 4087));
		if (pc >= 12'd4080) return {GRP_JP, tgt};
		case ($urandom_range(0, 19))
			0: op = OP_CLS;
			1: op = OP_RET;
			2: op = {GRP_JP, tgt};
			3: op = {GRP_CALL, tgt};
			4: op = {GRP_SEQK, 12'($urandom)};
			5: op = {GRP_SNEK, 12'($urandom)};
			6: op = {GRP_SEQV, 12'($urandom)};
			7: op = {GRP_LDK, 12'($urandom)};
			8: op = {GRP_ADDK, 12'($urandom)};
			9, 10: begin
				case ($urandom_range(0, 9))
					0: fn = ALU_MOV;
					1: fn = ALU_OR;
					2: fn = ALU_AND;
					3: fn = ALU_XOR;
					4: fn = ALU_ADD;
					5: fn = ALU_SUB;
					6: fn = ALU_SHR;
					7: fn = ALU_SBN;
					8: fn = ALU_SHL;
					default: begin
						fn = 4'($urandom_range(8, 15));
						if (fn == ALU_SHL) fn = 4'hF;
					end
				endcase
				op = {GRP_ALU, 8'($urandom), fn};
			end
			11: op = {GRP_SNEV, 12'($urandom)};
			12: op = {GRP_LDI, 12'($urandom)};
			13: op = {GRP_LDI, 12'($urandom_range(512, 4080))};
			14: op = {GRP_JPV0, 12'($urandom_range(512, 3800))};
			15, 16, 17: op = {GRP_DRW, 12'($urandom)};
			default: begin
				case ($urandom_range(0, 3))
					0: op = {GRP_RND, 12'($urandom)};
					1: op = {GRP_KEY, 12'($urandom)};
					2: op = {GRP_MISC, 12'($urandom)};
					default: begin
						op = {GRP_SYS, 12'($urandom)};
						if (op == OP_CLS || op == OP_RET) op = 16'h0123;
					end
				endcase
			end
		endcase
		// A sprite read must stay on written memory above the program base.
		if (op[15:12] == GRP_DRW && (idx < 12'd512 || idx > 12'd4080))
			op = {GRP_LDI, 12'($urandom_range(512, 4080))};
		return op;
	endfunction

	initial begin
		int r;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_gap_pct = 6;
		recv_stall_pct = 81;

		send_item(KIND_LOAD, 12'd0, 8'h00, 5'd0);
		send_item(KIND_LOAD, 12'd3583, 8'hFF, 5'd31);
		send_item(KIND_READ, 12'hFFF, 8'hFF, 5'd31);
		send_item(2'd3, 12'd0, 8'd0, 5'd0);
		run_op({GRP_LDK, 4'h0, 8'hFF});
		run_op({GRP_LDK, 4'h1, 8'h01});
		run_op({GRP_ALU, 4'h0, 4'h1, ALU_ADD});
		run_op({GRP_ALU, 4'h0, 4'h1, ALU_SUB});
		run_op({GRP_ALU, 4'h0, 4'h1, ALU_SBN});
		run_op({GRP_ALU, 4'h1, 4'h0, ALU_SHR});
		run_op({GRP_LDK, 4'h2, 8'h80});
		run_op({GRP_ALU, 4'h2, 4'h0, ALU_SHL});
		run_op({GRP_SEQV, 4'h0, 4'h1, 4'h7});
		run_op({GRP_SNEV, 4'h0, 4'h2, 4'h0});
		run_op({GRP_LDI, 12'h600});
		run_op({GRP_LDK, 4'h3, 8'd62});
		run_op({GRP_LDK, 4'h4, 8'd30});
		run_op({GRP_DRW, 4'h3, 4'h4, 4'hF});
		run_op({GRP_DRW, 4'h3, 4'h4, 4'hF});
		run_op({GRP_DRW, 4'h3, 4'h4, 4'h0});
		run_op(OP_CLS);
		run_op(OP_RET);
		run_op({GRP_ALU, 4'h0, 4'h1, 4'h8});
		run_op({GRP_MISC, 12'h000});
		run_op({GRP_JPV0, 12'h300});
		// Seventeen nested calls: the last one overflows, then the stack unwinds.
		for (int i = 0; i < 17; i++) run_op({GRP_CALL, cur_pc + 12'd2});
		for (int i = 0; i < 16; i++) run_op(OP_RET);

		for (int ph = 0; ph < 3; ph++) begin
			send_gap_pct = (ph == 0) ? 6 : (ph == 1) ? 81 : 0;
			recv_stall_pct = (ph == 0) ? 81 : (ph == 1) ? 6 : 0;
			while (items_sent < (ph + 1) * ITEM_TARGET / 3) begin
				r = $urandom_range(99);
				if (r < 8)
					send_item(KIND_LOAD, 12'($urandom_range(0, 3583)), 8'($urandom),
						5'($urandom));
				else if (r < 14)
					send_item(2'($urandom_range(2, 3)), 12'($urandom), 8'($urandom),
						5'($urandom));
				else
					run_op(pick_op(cur_pc, cur_idx));
			end
		end

		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** chip8_instruction_core_top: PASSED **");
		else
			$display("** chip8_instruction_core_top: FAILED **");
		$finish;
	end
endmodule
